// ===== hw/rtl/dclk_pkg.sv =====
// Shared types, constants and helper functions for the lock-to-key encoder.
`default_nettype none

package dclk_pkg;

   localparam int MAX_LOCK_LEN = 1024;
   localparam int CNT_W        = $clog2(MAX_LOCK_LEN + 2);
   localparam int POS_W        = 10;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam int CMP_W        = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ESC_LAST_STEP = 4'd9;

   localparam logic [7:0] FIRST_XOR = 8'h05;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_N      = 8'h4e;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef struct packed {
      logic [7:0] lock_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]       key_byte;
      logic [POS_W-1:0] key_position;
      logic             last_of_run;
      logic             key_complete;
      logic             too_short;
      logic             overflow;
   } rsp_type;

   // One queued job: element A from the current byte, optional element 0 (B).
   typedef struct packed {
      logic             too_short;
      logic [7:0]       a_val;
      logic [POS_W-1:0] a_pos;
      logic             a_ovf;
      logic             has_b;
      logic [7:0]       b_val;
      logic             b_ovf;
   } job_type;

   function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
      return {v[3:0], v[7:4]};
   endfunction

   function automatic logic needs_escape(input logic [7:0] v);
      return (v == 8'd0) || (v == 8'd5) || (v == 8'd36) || (v == 8'd96) ||
             (v == 8'd124) || (v == 8'd126);
   endfunction

   // Byte number step of the escape sequence /%DCNddd%/ for value v.
   function automatic logic [7:0] escape_byte(input logic [7:0] v,
                                              input logic [STEP_W-1:0] step);
      logic [3:0] d2;
      logic [3:0] d1;
      logic [3:0] d0;
      logic [7:0] r;
      unique case (v)
         8'd5:    {d2, d1, d0} = {4'd0, 4'd0, 4'd5};
         8'd36:   {d2, d1, d0} = {4'd0, 4'd3, 4'd6};
         8'd96:   {d2, d1, d0} = {4'd0, 4'd9, 4'd6};
         8'd124:  {d2, d1, d0} = {4'd1, 4'd2, 4'd4};
         8'd126:  {d2, d1, d0} = {4'd1, 4'd2, 4'd6};
         default: {d2, d1, d0} = {4'd0, 4'd0, 4'd0};
      endcase
      unique case (step)
         4'd0:    r = CH_SLASH;
         4'd1:    r = CH_PCT;
         4'd2:    r = CH_D;
         4'd3:    r = CH_C;
         4'd4:    r = CH_N;
         4'd5:    r = CH_ZERO | {4'd0, d2};
         4'd6:    r = CH_ZERO | {4'd0, d1};
         4'd7:    r = CH_ZERO | {4'd0, d0};
         4'd8:    r = CH_PCT;
         default: r = CH_SLASH;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dclk_front.sv =====
// Front end: accepts lock bytes, tracks the lock and builds key jobs.
`default_nettype none

module dclk_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dclk_pkg::req_type req_data,
   input  wire logic              q_full,
   output logic                   job_push,
   output dclk_pkg::job_type      job_data
);

   logic [7:0]                 first_swapped_ff, first_swapped_in;
   logic [7:0]                 prev_byte_ff, prev_byte_in;
   logic [dclk_pkg::CNT_W-1:0] count_ff, count_in;

   logic                       accept;
   logic [7:0]                 elem_val;
   logic [dclk_pkg::CNT_W-1:0] pos_sat;
   logic [dclk_pkg::CMP_W-1:0] pos_wide;
   logic [dclk_pkg::POS_W-1:0] pos;
   logic                       ovf;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign elem_val = dclk_pkg::swap_nibbles(req_data.lock_byte ^ prev_byte_ff);
   assign pos_sat  = (count_ff < dclk_pkg::CNT_W'(dclk_pkg::MAX_LOCK_LEN)) ? count_ff :
                     dclk_pkg::CNT_W'(dclk_pkg::MAX_LOCK_LEN - 1);
   assign pos_wide = dclk_pkg::CMP_W'(pos_sat);
   assign pos      = (pos_wide > dclk_pkg::CMP_W'(dclk_pkg::POS_MAX)) ?
                     dclk_pkg::POS_W'(dclk_pkg::POS_MAX) : pos_wide[dclk_pkg::POS_W-1:0];
   // The count never steps past the limit by more than one, so the overflow
   // of element 0 matches that of the final element.
   assign ovf      = count_ff >= dclk_pkg::CNT_W'(dclk_pkg::MAX_LOCK_LEN);

   always_comb begin
      first_swapped_in = first_swapped_ff;
      prev_byte_in     = prev_byte_ff;
      count_in         = count_ff;
      job_push         = 1'b0;
      job_data         = '0;
      job_data.a_val   = elem_val;
      job_data.a_pos   = pos;
      job_data.a_ovf   = ovf;
      job_data.b_val   = first_swapped_ff ^ elem_val;
      job_data.b_ovf   = ovf;
      if (accept) begin
         priority if (count_ff == '0) begin
            first_swapped_in = dclk_pkg::swap_nibbles(req_data.lock_byte ^
                                                      dclk_pkg::FIRST_XOR);
            prev_byte_in     = req_data.lock_byte;
            count_in         = dclk_pkg::CNT_W'(1);
            if (req_data.last_byte) begin
               job_push           = 1'b1;
               job_data.too_short = 1'b1;
               count_in           = '0;
            end
         end else if (req_data.last_byte && count_ff == dclk_pkg::CNT_W'(1)) begin
            job_push           = 1'b1;
            job_data.too_short = 1'b1;
            count_in           = '0;
         end else begin
            job_push     = 1'b1;
            prev_byte_in = req_data.lock_byte;
            if (count_ff <= dclk_pkg::CNT_W'(dclk_pkg::MAX_LOCK_LEN)) begin
               count_in = count_ff + dclk_pkg::CNT_W'(1);
            end
            if (req_data.last_byte) begin
               job_data.has_b = 1'b1;
               count_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_swapped_ff <= '0;
         prev_byte_ff     <= '0;
         count_ff         <= '0;
      end else begin
         first_swapped_ff <= first_swapped_in;
         prev_byte_ff     <= prev_byte_in;
         count_ff         <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dclk_queue.sv =====
// Small job queue between the front end and the expander.
`default_nettype none

module dclk_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dclk_pkg::job_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output dclk_pkg::job_type      head_data
);

   dclk_pkg::job_type           entry_ff [dclk_pkg::QUEUE_DEPTH];
   logic [dclk_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dclk_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dclk_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == dclk_pkg::QCNT_W'(dclk_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + dclk_pkg::QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + dclk_pkg::QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + dclk_pkg::QCNT_W'(push) - dclk_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/dclk_back.sv =====
// Back end: expands queued jobs into key bytes and holds the response register.
`default_nettype none

module dclk_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire dclk_pkg::job_type job_data,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dclk_pkg::rsp_type      rsp_data
);

   logic                        out_valid_ff, out_valid_in;
   dclk_pkg::rsp_type           out_data_ff, out_data_in;
   logic [dclk_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        elem_b_ff, elem_b_in;

   logic                        load;
   logic [7:0]                  val;
   logic                        esc;
   logic                        elem_last;
   logic                        job_last;

   assign val       = elem_b_ff ? job_data.b_val : job_data.a_val;
   assign esc       = dclk_pkg::needs_escape(val) && !job_data.too_short;
   assign elem_last = !esc || (step_ff == dclk_pkg::ESC_LAST_STEP);
   assign job_last  = job_data.too_short || (elem_last && (elem_b_ff || !job_data.has_b));

   // The register takes a new byte whenever it is empty or being drained.
   assign load    = job_valid && (!out_valid_ff || rsp_ready);
   assign job_pop = load && job_last;

   always_comb begin
      out_data_in              = '0;
      out_data_in.key_byte     = esc ? dclk_pkg::escape_byte(val, step_ff) : val;
      out_data_in.key_position = elem_b_ff ? '0 : job_data.a_pos;
      out_data_in.last_of_run  = job_last;
      out_data_in.key_complete = job_last && job_data.has_b;
      out_data_in.overflow     = elem_b_ff ? job_data.b_ovf : job_data.a_ovf;
      if (job_data.too_short) begin
         out_data_in              = '0;
         out_data_in.last_of_run  = 1'b1;
         out_data_in.key_complete = 1'b1;
         out_data_in.too_short    = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      step_in      = step_ff;
      elem_b_in    = elem_b_ff;
      if (load) begin
         out_valid_in = 1'b1;
         if (elem_last) begin
            step_in   = '0;
            elem_b_in = !job_last;
         end else begin
            step_in = step_ff + dclk_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         elem_b_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         elem_b_ff    <= elem_b_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_escape_has_job: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0 || elem_b_ff) |-> job_valid)
      else $error("expander mid-job without a queued job");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= dclk_pkg::ESC_LAST_STEP)
      else $error("escape step out of range");

   a_complete_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_complete) |-> rsp_data.last_of_run)
      else $error("key completed on a byte that does not end its run");

endmodule

`default_nettype wire

// ===== hw/rtl/dc_lock_to_key_encoder_top.sv =====
// Top level of the lock-to-key encoder: front end, job queue and expander.
//
// Lock bytes enter one per request; in a lock of three bytes or more, each
// byte after the first yields one key element, plain as one response or
// escaped as the ten responses /%DCNddd%/, and a shorter lock yields one
// too-short response. The final byte also yields key element 0, so it takes
// two elements' worth of responses. The expander emits one response per cycle
// when not stalled, so the sustained rate is one request per cycle while
// elements stay plain; an escaped element holds the expander for its ten
// responses, and the four-entry job queue absorbs that before requests stall.
// A request's first response passes the job queue and the response register.
// Every response carries its key position, and key element 0 arrives last.
`default_nettype none

module dc_lock_to_key_encoder_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dclk_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dclk_pkg::rsp_type      rsp_data
);

   logic              q_full;
   logic              job_push;
   dclk_pkg::job_type job_in;
   logic              job_pop;
   logic              job_valid;
   dclk_pkg::job_type job_head;

   dclk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .job_push  (job_push),
      .job_data  (job_in)
   );

   dclk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .full       (q_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_head)
   );

   dclk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb_dc_lock_to_key_encoder_top.sv =====
// Self-checking testbench for the lock-to-key encoder top level.
`default_nettype none

module tb_dc_lock_to_key_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 500_000;
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned ITEMS_PER_SET = 60;
   localparam logic [7:0] ESC_VALUES [6] = '{8'd0, 8'd5, 8'd36, 8'd96, 8'd124, 8'd126};

   // Predicts the key bytes of each lock and checks the responses in order.
   class key_tracker;
      logic [7:0]         first_swapped;
      logic [7:0]         prev_byte;
      int unsigned        byte_count;
      dclk_pkg::rsp_type  expected_keys[$];
      int unsigned        errors;

      function new();
         first_swapped = '0;
         prev_byte     = '0;
         byte_count    = 0;
         errors        = 0;
      endfunction

      static function logic [7:0] nib_swap(logic [7:0] v);
         return {v[3:0], v[7:4]};
      endfunction

      function int unsigned pending();
         return expected_keys.size();
      endfunction

      function void push_key_byte(logic [7:0] b, logic [dclk_pkg::POS_W-1:0] pos,
                                  logic ovf);
         dclk_pkg::rsp_type r;
         r = '0;
         r.key_byte     = b;
         r.key_position = pos;
         r.overflow     = ovf;
         expected_keys.push_back(r);
      endfunction

      function void push_element(logic [7:0] v, logic [dclk_pkg::POS_W-1:0] pos,
                                 logic ovf);
         logic [7:0] seq [10];
         int k;
         if (v inside {8'd0, 8'd5, 8'd36, 8'd96, 8'd124, 8'd126}) begin
            seq = '{dclk_pkg::CH_SLASH, dclk_pkg::CH_PCT, dclk_pkg::CH_D,
                    dclk_pkg::CH_C, dclk_pkg::CH_N,
                    8'(48 + v / 100), 8'(48 + (v / 10) % 10), 8'(48 + v % 10),
                    dclk_pkg::CH_PCT, dclk_pkg::CH_SLASH};
            for (k = 0; k < 10; k++) push_key_byte(seq[k], pos, ovf);
         end else begin
            push_key_byte(v, pos, ovf);
         end
      endfunction

      function void note_lock_byte(dclk_pkg::req_type q);
         dclk_pkg::rsp_type          r;
         logic [7:0]                 elem;
         logic [dclk_pkg::POS_W-1:0] pos;
         logic                       ovf;
         if (byte_count == 0) begin
            first_swapped = nib_swap(q.lock_byte ^ dclk_pkg::FIRST_XOR);
            prev_byte     = q.lock_byte;
            byte_count    = 1;
            if (!q.last_byte) return;
         end
         if (q.last_byte && byte_count <= 1) begin
            r = '0;
            r.last_of_run  = 1'b1;
            r.key_complete = 1'b1;
            r.too_short    = 1'b1;
            expected_keys.push_back(r);
            byte_count = 0;
            return;
         end
         pos = (byte_count < dclk_pkg::MAX_LOCK_LEN) ? dclk_pkg::POS_W'(byte_count) :
               dclk_pkg::POS_W'(dclk_pkg::MAX_LOCK_LEN - 1);
         if (byte_count > dclk_pkg::POS_MAX && byte_count < dclk_pkg::MAX_LOCK_LEN)
            pos = dclk_pkg::POS_W'(dclk_pkg::POS_MAX);
         ovf  = (byte_count >= dclk_pkg::MAX_LOCK_LEN);
         elem = nib_swap(q.lock_byte ^ prev_byte);
         prev_byte = q.lock_byte;
         push_element(elem, pos, ovf);
         if (byte_count <= dclk_pkg::MAX_LOCK_LEN) byte_count++;
         if (q.last_byte) begin
            // Key element 0 closes the key and is flagged if the lock ran long.
            push_element(first_swapped ^ elem, '0, byte_count > dclk_pkg::MAX_LOCK_LEN);
            byte_count = 0;
         end
         r = expected_keys.pop_back();
         r.last_of_run  = 1'b1;
         r.key_complete = q.last_byte;
         expected_keys.push_back(r);
      endfunction

      function void compare_field(string name, logic [dclk_pkg::POS_W-1:0] exp_v,
                                  logic [dclk_pkg::POS_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_key_byte(dclk_pkg::rsp_type got);
         dclk_pkg::rsp_type want;
         if (expected_keys.size() == 0) begin
            $error("key_byte expected none actual %0h", got.key_byte);
            errors++;
            return;
         end
         want = expected_keys.pop_front();
         compare_field("key_byte", dclk_pkg::POS_W'(want.key_byte),
                       dclk_pkg::POS_W'(got.key_byte));
         compare_field("key_position", want.key_position, got.key_position);
         compare_field("last_of_run", dclk_pkg::POS_W'(want.last_of_run),
                       dclk_pkg::POS_W'(got.last_of_run));
         compare_field("key_complete", dclk_pkg::POS_W'(want.key_complete),
                       dclk_pkg::POS_W'(got.key_complete));
         compare_field("too_short", dclk_pkg::POS_W'(want.too_short),
                       dclk_pkg::POS_W'(got.too_short));
         compare_field("overflow", dclk_pkg::POS_W'(want.overflow),
                       dclk_pkg::POS_W'(got.overflow));
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dclk_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dclk_pkg::rsp_type rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;

   key_tracker keys = new();

   dc_lock_to_key_encoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) keys.check_key_byte(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      dclk_pkg::req_type q;
      q.lock_byte = b;
      q.last_byte = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      keys.note_lock_byte(q);
   endtask

   // Sends the lock byte that makes the next key element equal v.
   task automatic send_element(input logic [7:0] v, input logic last);
      send_byte(keys.prev_byte ^ key_tracker::nib_swap(v), last);
   endtask

   // Always waits on the clock before checking, so the next drive lands in a later step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (keys.pending() != 0);
   endtask

   task automatic send_random_lock(input int unsigned len);
      int unsigned i;
      logic        last;
      logic [7:0]  esc;
      for (i = 0; i < len; i++) begin
         last = (i == len - 1);
         esc  = ESC_VALUES[$urandom_range(5)];
         if (i > 0 && last && $urandom_range(99) < 20)
            send_element(keys.first_swapped ^ esc, last);
         else if (i > 0 && $urandom_range(99) < 15)
            send_element(esc, last);
         else
            send_byte(8'($urandom), last);
      end
   endtask

   task automatic run_random_set();
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      sent = 0;
      while (sent < ITEMS_PER_SET) begin
         pick = $urandom_range(99);
         if (pick < 10)      len = $urandom_range(2, 1);
         else if (pick < 85) len = $urandom_range(12, 3);
         else                len = $urandom_range(40, 13);
         send_random_lock(len);
         sent += len;
         if ($urandom_range(19) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-byte and two-byte locks are both too short; a three-byte lock is not.
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      // Every escaped value once, then key element 0 escaped as well.
      send_byte(8'ha5, 1'b0);
      for (k = 0; k < 6; k++) send_element(ESC_VALUES[k], 1'b0);
      send_element(keys.first_swapped, 1'b1);
      // Last byte and key element 0 both escaped: the longest response run.
      send_byte(key_tracker::nib_swap(8'd36 ^ 8'd124) ^ dclk_pkg::FIRST_XOR, 1'b0);
      send_element(8'd126, 1'b0);
      send_element(8'd36, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      wait_drained();

      send_idle_pct = 0;  stall_pct = 0;  run_random_set();
      send_idle_pct = 81; stall_pct = 0;  run_random_set();
      send_idle_pct = 0;  stall_pct = 81; run_random_set();
      send_idle_pct = 9;  stall_pct = 9;  run_random_set();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (keys.errors == 0 && keys.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
